/* hw/rtl/udp_port_magic_packet_filter_core_assert.svh */
// Assertion macros for the packet filter core.
// Included by the RTL files that carry concurrent checks; no other dependency.
`ifndef UDP_PORT_MAGIC_PACKET_FILTER_CORE_ASSERT_SVH
`define UDP_PORT_MAGIC_PACKET_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UPMPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("upmpf check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UPMPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("upmpf check failed");

`endif

/* hw/rtl/upmpf_pkg.sv */
// Shared constants and types for the UDP port / magic word packet filter.
// No dependencies; used by the channel interfaces and the core.
package upmpf_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int TOTAL_W         = 32;
  localparam int CFG_INDEX_W     = 8;
  localparam int CFG_DATA_W      = 32;
  localparam int OFFSET_W        = 7;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = 7'd127;

  // Header geometry in bytes from the dest MAC; UDP_* from the UDP header.
  localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;
  localparam logic [7:0]  ETYPE_HI_POS   = 8'd12;
  localparam logic [7:0]  ETYPE_LO_POS   = 8'd13;
  localparam logic [7:0]  IP_PROTO_POS   = 8'd23;
  localparam logic [7:0]  IPV4_MIN_END   = 8'd34;
  localparam logic [7:0]  UDP_DPORT_HI   = 8'd2;
  localparam logic [7:0]  UDP_DPORT_LO   = 8'd3;
  localparam logic [7:0]  UDP_HDR_LEN    = 8'd8;
  localparam logic [7:0]  MAGIC_LEN      = 8'd4;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [3:0]  MIN_IHL        = 4'd5;

  // Configuration registers
  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_PORT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_WORD = 8'd1;
  localparam logic [15:0] MATCH_PORT_RST = 16'd7777;
  localparam logic [31:0] MAGIC_WORD_RST = 32'h4950_3756;

  localparam logic VERDICT_PASS = 1'b0;
  localparam logic VERDICT_DROP = 1'b1;

  typedef enum logic [1:0] {
    CNT_RX_ONLY = 2'd0,
    CNT_PASSED  = 2'd1,
    CNT_DROPPED = 2'd2
  } count_kind_t;

endpackage

/* hw/rtl/upmpf_ifs.sv */
// Valid/ready channel interfaces for the packet filter: frame bytes in,
// verdicts out, and register writes. Depends on upmpf_pkg.
interface upmpf_in_if import upmpf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

interface upmpf_out_if import upmpf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               verdict;
  logic [1:0]         counted_as;
  logic [TOTAL_W-1:0] received_total;
  logic [TOTAL_W-1:0] passed_total;
  logic [TOTAL_W-1:0] dropped_total;

  modport source (output valid, verdict, counted_as, received_total, passed_total,
                  dropped_total, input ready);
  modport sink   (input valid, verdict, counted_as, received_total, passed_total,
                  dropped_total, output ready);
endinterface

interface upmpf_cfg_if import upmpf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/udp_port_magic_packet_filter_core.sv */
// Top level of the UDP port / magic word packet filter.
// Depends on upmpf_pkg, the channel interfaces and the assertion macro header.
`include "udp_port_magic_packet_filter_core_assert.svh"

// Takes one Ethernet frame byte per cycle, frame_end marking the last byte, and
// gives one verdict request per frame: drop only for IPv4/UDP to match_port whose
// first four payload bytes are missing or differ from magic_word. Header fields
// are captured as bytes stream past; the last byte's summary goes into a summary
// register; once the result register is free it is judged, the wrapping counters
// bumped and the result register loaded, so the verdict passes through both.
// One byte per cycle holds while the sink takes results; in_ready drops only
// while a summary waits on an untaken result. Register writes are always taken.
module udp_port_magic_packet_filter_core
  import upmpf_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  upmpf_in_if.sink    in_ch,
  upmpf_out_if.source out_ch,
  upmpf_cfg_if.sink   cfg_ch
);

  typedef struct packed {
    logic [OFFSET_W-1:0] len;
    logic [15:0]         ether_type;
    logic [3:0]          header_words;
    logic [7:0]          ip_protocol;
    logic [15:0]         dest_port;
    logic [31:0]         payload_word;
  } frame_sum_t;

  // Configuration
  logic [15:0] match_port_r;
  logic [31:0] magic_word_r;

  // Capture state
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [15:0]         ether_r, ether_nxt;
  logic [3:0]          ihl_r, ihl_nxt;
  logic [7:0]          proto_r, proto_nxt;
  logic [15:0]         dport_r, dport_nxt;
  logic [31:0]         payload_r, payload_nxt;

  // Summary and result stages
  logic       sum_v_r;
  frame_sum_t sum_r;
  logic       out_v_r;
  logic       verdict_r;
  count_kind_t kind_r, kind_nxt;
  logic [TOTAL_W-1:0] rx_tot_r, pass_tot_r, drop_tot_r;

  logic [COUNT_WIDTH-1:0] rx_r, rx_nxt, pass_r, pass_nxt, drop_r, drop_nxt;

  logic       in_acc, out_free, sum_move, sum_free;
  logic [7:0] pos, udp_start, u_start_j, len_j;

  assign out_free = !out_v_r || out_ch.ready;
  assign sum_move = sum_v_r && out_free;
  assign sum_free = !sum_v_r || out_free;
  assign in_ch.ready = sum_free;
  assign in_acc = in_ch.valid && sum_free;
  assign cfg_ch.ready = 1'b1;

  // ---------------- byte capture ----------------
  assign pos       = {1'b0, offset_r};
  assign udp_start = ETH_HDR_LEN + {2'b00, ihl_r, 2'b00};

  always_comb begin
    ether_nxt   = ether_r;
    ihl_nxt     = ihl_r;
    proto_nxt   = proto_r;
    dport_nxt   = dport_r;
    payload_nxt = payload_r;
    if (pos == ETYPE_HI_POS || pos == ETYPE_LO_POS) begin
      ether_nxt = {ether_r[7:0], in_ch.frame_byte};
    end
    if (pos == ETH_HDR_LEN) begin
      ihl_nxt = in_ch.frame_byte[3:0];
    end
    if (pos == IP_PROTO_POS) begin
      proto_nxt = in_ch.frame_byte;
    end
    // ihl_r is already settled once past the first IPv4 byte
    if (pos > ETH_HDR_LEN) begin
      if (pos == udp_start + UDP_DPORT_HI || pos == udp_start + UDP_DPORT_LO) begin
        dport_nxt = {dport_r[7:0], in_ch.frame_byte};
      end
      if (pos >= udp_start + UDP_HDR_LEN && pos < udp_start + UDP_HDR_LEN + MAGIC_LEN) begin
        payload_nxt = {payload_r[23:0], in_ch.frame_byte};
      end
    end
    offset_nxt = (offset_r < OFFSET_MAX) ? offset_r + 1'b1 : OFFSET_MAX;
  end

  // ---------------- judgment ----------------
  assign len_j     = {1'b0, sum_r.len};
  assign u_start_j = ETH_HDR_LEN + {2'b00, sum_r.header_words, 2'b00};

  always_comb begin
    priority if (len_j < ETH_HDR_LEN) begin
      kind_nxt = CNT_RX_ONLY;
    end else if (sum_r.ether_type != ETHERTYPE_IPV4) begin
      kind_nxt = CNT_PASSED;
    end else if (len_j < IPV4_MIN_END) begin
      kind_nxt = CNT_RX_ONLY;
    end else if (sum_r.ip_protocol != PROTO_UDP) begin
      kind_nxt = CNT_PASSED;
    end else if (sum_r.header_words < MIN_IHL) begin
      kind_nxt = CNT_RX_ONLY;
    end else if (len_j < u_start_j + UDP_HDR_LEN) begin
      kind_nxt = CNT_RX_ONLY;
    end else if (sum_r.dest_port != match_port_r) begin
      kind_nxt = CNT_PASSED;
    end else if (len_j < u_start_j + UDP_HDR_LEN + MAGIC_LEN) begin
      kind_nxt = CNT_DROPPED;   // payload too short for the magic word
    end else if (sum_r.payload_word == magic_word_r) begin
      kind_nxt = CNT_PASSED;
    end else begin
      kind_nxt = CNT_DROPPED;
    end
  end

  assign rx_nxt   = rx_r + 1'b1;
  assign pass_nxt = (kind_nxt == CNT_PASSED)  ? pass_r + 1'b1 : pass_r;
  assign drop_nxt = (kind_nxt == CNT_DROPPED) ? drop_r + 1'b1 : drop_r;

  // ---------------- control and capture registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_port_r <= MATCH_PORT_RST;
      magic_word_r <= MAGIC_WORD_RST;
      offset_r     <= '0;
      ether_r      <= '0;
      ihl_r        <= '0;
      proto_r      <= '0;
      dport_r      <= '0;
      payload_r    <= '0;
      sum_v_r      <= 1'b0;
      out_v_r      <= 1'b0;
      rx_r         <= '0;
      pass_r       <= '0;
      drop_r       <= '0;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.index == CFG_MATCH_PORT) begin
          match_port_r <= cfg_ch.data[15:0];
        end else if (cfg_ch.index == CFG_MAGIC_WORD) begin
          magic_word_r <= cfg_ch.data;
        end
      end
      if (in_acc) begin
        if (in_ch.frame_end) begin
          offset_r  <= '0;
          ether_r   <= '0;
          ihl_r     <= '0;
          proto_r   <= '0;
          dport_r   <= '0;
          payload_r <= '0;
        end else begin
          offset_r  <= offset_nxt;
          ether_r   <= ether_nxt;
          ihl_r     <= ihl_nxt;
          proto_r   <= proto_nxt;
          dport_r   <= dport_nxt;
          payload_r <= payload_nxt;
        end
      end
      if (in_acc && in_ch.frame_end) begin
        sum_v_r <= 1'b1;
      end else if (sum_move) begin
        sum_v_r <= 1'b0;
      end
      if (out_free) begin
        out_v_r <= sum_v_r;
      end
      if (sum_move) begin
        rx_r   <= rx_nxt;
        pass_r <= pass_nxt;
        drop_r <= drop_nxt;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.frame_end) begin
      sum_r.len          <= offset_nxt;
      sum_r.ether_type   <= ether_nxt;
      sum_r.header_words <= ihl_nxt;
      sum_r.ip_protocol  <= proto_nxt;
      sum_r.dest_port    <= dport_nxt;
      sum_r.payload_word <= payload_nxt;
    end
    if (sum_move) begin
      verdict_r  <= (kind_nxt == CNT_DROPPED) ? VERDICT_DROP : VERDICT_PASS;
      kind_r     <= kind_nxt;
      rx_tot_r   <= TOTAL_W'(rx_nxt);
      pass_tot_r <= TOTAL_W'(pass_nxt);
      drop_tot_r <= TOTAL_W'(drop_nxt);
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.verdict        = verdict_r;
  assign out_ch.counted_as     = kind_r;
  assign out_ch.received_total = rx_tot_r;
  assign out_ch.passed_total   = pass_tot_r;
  assign out_ch.dropped_total  = drop_tot_r;

  // ---------------- checks ----------------
  `UPMPF_ASSERT_NOW(a_verdict_matches_kind, clk, rst_n, out_v_r,
                    (verdict_r == VERDICT_DROP) == (kind_r == CNT_DROPPED))
  `UPMPF_ASSERT_NEXT(a_rx_counts_each_verdict, clk, rst_n, sum_move,
                     rx_r == COUNT_WIDTH'($past(rx_r) + 1'b1))
  `UPMPF_ASSERT_NEXT(a_frame_end_clears_offset, clk, rst_n, in_acc && in_ch.frame_end,
                     offset_r == '0 && sum_v_r)
  `UPMPF_ASSERT_NEXT(a_summary_held_when_blocked, clk, rst_n, sum_v_r && !out_free,
                     sum_v_r && out_v_r)

endmodule
